[src/ftce_pkg.sv]
package ftce_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       mask_bit;
        logic       last_pixel;
    } ftce_pix_t;

    typedef struct packed {
        logic [31:0] full_frame_crc;
        logic [31:0] masked_pixel_crc;
        logic [31:0] plane0_crc;
        logic [31:0] plane1_crc;
        logic [31:0] masked_plane0_crc;
    } ftce_hash_t;

    // reflected crc-32, one byte per call, plain xor network after synthesis
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[src/frame_trigger_crc_engine.sv]
// channel | valid      | ready      | payload
// --------+------------+------------+------------------------------------
// pix     | pix_valid  | pix_ready  | pix  (pixel byte, mask bit, last)
// hash    | hash_valid | hash_ready | hash (five finished crc-32 values)
//
// one pixel request per cycle sustained unless a last pixel waits on a
// stalled hash output; five byte-wide crc updates run on the input register,
// and the last pixel's hashes appear in the output register the cycle after.
// reset clears all five crcs to all ones and the packing state to zero.
// a stalled hash output holds back a pending last pixel and all input behind
// it; mid-frame pixels flow on, and the input register frees as it advances.
module frame_trigger_crc_engine
    import ftce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  ftce_pix_t  pix,
    output logic       hash_valid,
    input  logic       hash_ready,
    output ftce_hash_t hash
);

    logic        s1_valid_reg;
    ftce_pix_t   s1_reg;
    logic        s1_advance;

    logic [31:0] full_crc_reg,  full_crc_next;
    logic [31:0] mpix_crc_reg,  mpix_crc_next;
    logic [31:0] p0_crc_reg,    p0_crc_next;
    logic [31:0] p1_crc_reg,    p1_crc_next;
    logic [31:0] mp0_crc_reg,   mp0_crc_next;
    logic [7:0]  p0_pack_reg,   p0_pack_next;
    logic [7:0]  p1_pack_reg,   p1_pack_next;
    logic [7:0]  mp0_pack_reg,  mp0_pack_next;
    logic [2:0]  bit_pos_reg,   bit_pos_next;

    logic        hash_valid_reg;
    ftce_hash_t  hash_reg;

    logic [7:0]  p0_fill, p1_fill, mp0_fill;
    logic        byte_done;

    // a last pixel needs the output register free; others never wait
    assign s1_advance = s1_valid_reg
                        && (!s1_reg.last_pixel || !hash_valid_reg || hash_ready);
    assign pix_ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            s1_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix_valid)
        begin
            s1_reg <= pix;
        end
    end

    always_comb
    begin
        p0_fill   = p0_pack_reg  | ({7'd0, s1_reg.pixel_value[0]} << bit_pos_reg);
        p1_fill   = p1_pack_reg  | ({7'd0, s1_reg.pixel_value[1]} << bit_pos_reg);
        mp0_fill  = mp0_pack_reg
                    | ({7'd0, s1_reg.pixel_value[0] & s1_reg.mask_bit} << bit_pos_reg);
        byte_done = (bit_pos_reg == 3'd7);

        full_crc_next = crc_byte(full_crc_reg, s1_reg.pixel_value);
        mpix_crc_next = s1_reg.mask_bit ? crc_byte(mpix_crc_reg, s1_reg.pixel_value)
                                        : mpix_crc_reg;
        p0_crc_next   = byte_done ? crc_byte(p0_crc_reg, p0_fill)   : p0_crc_reg;
        p1_crc_next   = byte_done ? crc_byte(p1_crc_reg, p1_fill)   : p1_crc_reg;
        mp0_crc_next  = byte_done ? crc_byte(mp0_crc_reg, mp0_fill) : mp0_crc_reg;
        p0_pack_next  = byte_done ? 8'd0 : p0_fill;
        p1_pack_next  = byte_done ? 8'd0 : p1_fill;
        mp0_pack_next = byte_done ? 8'd0 : mp0_fill;
        bit_pos_next  = bit_pos_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_crc_reg <= CRC_ONES;
            mpix_crc_reg <= CRC_ONES;
            p0_crc_reg   <= CRC_ONES;
            p1_crc_reg   <= CRC_ONES;
            mp0_crc_reg  <= CRC_ONES;
            p0_pack_reg  <= 8'd0;
            p1_pack_reg  <= 8'd0;
            mp0_pack_reg <= 8'd0;
            bit_pos_reg  <= 3'd0;
        end
        else if (s1_advance)
        begin
            if (s1_reg.last_pixel)
            begin
                // frame done, start the next one clean
                full_crc_reg <= CRC_ONES;
                mpix_crc_reg <= CRC_ONES;
                p0_crc_reg   <= CRC_ONES;
                p1_crc_reg   <= CRC_ONES;
                mp0_crc_reg  <= CRC_ONES;
                p0_pack_reg  <= 8'd0;
                p1_pack_reg  <= 8'd0;
                mp0_pack_reg <= 8'd0;
                bit_pos_reg  <= 3'd0;
            end
            else
            begin
                full_crc_reg <= full_crc_next;
                mpix_crc_reg <= mpix_crc_next;
                p0_crc_reg   <= p0_crc_next;
                p1_crc_reg   <= p1_crc_next;
                mp0_crc_reg  <= mp0_crc_next;
                p0_pack_reg  <= p0_pack_next;
                p1_pack_reg  <= p1_pack_next;
                mp0_pack_reg <= mp0_pack_next;
                bit_pos_reg  <= bit_pos_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_reg.last_pixel)
        begin
            hash_valid_reg <= 1'b1;
        end
        else if (hash_ready)
        begin
            hash_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_reg.last_pixel)
        begin
            hash_reg.full_frame_crc    <= full_crc_next ^ CRC_ONES;
            hash_reg.masked_pixel_crc  <= mpix_crc_next ^ CRC_ONES;
            hash_reg.plane0_crc        <= p0_crc_next   ^ CRC_ONES;
            hash_reg.plane1_crc        <= p1_crc_next   ^ CRC_ONES;
            hash_reg.masked_plane0_crc <= mp0_crc_next  ^ CRC_ONES;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash       = hash_reg;

    // pixels that end no frame never stall in the input register
    a_mid_frame_flows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_reg.last_pixel |-> s1_advance)
        else $error("mid-frame pixel stalled");

    // a frame end restarts the packing slot
    a_frame_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_reg.last_pixel |=> bit_pos_reg == 3'd0
                                            && full_crc_reg == CRC_ONES)
        else $error("state not restarted after frame end");

    // packing registers hold no bits at or above the current slot
    a_pack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((p0_pack_reg | p1_pack_reg | mp0_pack_reg) >> bit_pos_reg) == 8'd0)
        else $error("stray bits in packing registers");

    // masked plane bits are a subset of plane-0 bits
    a_mask_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (mp0_pack_reg & ~p0_pack_reg) == 8'd0)
        else $error("masked plane bit without plane-0 bit");

    // a new hash only comes from an advancing last pixel
    a_hash_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid_reg) |-> $past(s1_advance && s1_reg.last_pixel))
        else $error("hash appeared without a frame end");

endmodule
